FILE: src/lrt_pkg.sv
// ============================================================================
// lrt_pkg: shared types and constants for the locomotive refresh table
// Table geometry, command and status codes, and the entry, command and probe
// records that pass between the control logic and the row of table cells.
// ============================================================================
`default_nettype none

package lrt_pkg;

    // Table geometry.
    localparam int TABLE_DEPTH = 8;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    // Field widths.
    localparam int KIND_W = 3;
    localparam int ADDR_W = 8;
    localparam int SPD_W  = 8;
    localparam int FBIT_W = 3;
    localparam int FUNC_W = 8;
    localparam int STAT_W = 3;

    // Reset contents of the table.
    localparam logic [ADDR_W-1:0] ADDR_SLOT0_RESET = 8'd99;
    localparam logic [FUNC_W-1:0] FUNC_RESET       = 8'h80;

    // Command codes.
    localparam logic [KIND_W-1:0] K_ADD   = 3'd0;
    localparam logic [KIND_W-1:0] K_SPEED = 3'd1;
    localparam logic [KIND_W-1:0] K_DIR   = 3'd2;
    localparam logic [KIND_W-1:0] K_FUNC  = 3'd3;
    localparam logic [KIND_W-1:0] K_NEXT  = 3'd4;

    // Status codes.
    localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
    localparam logic [STAT_W-1:0] ST_NOT_FOUND = 3'd1;
    localparam logic [STAT_W-1:0] ST_PRESENT   = 3'd2;
    localparam logic [STAT_W-1:0] ST_FULL      = 3'd3;
    localparam logic [STAT_W-1:0] ST_EMPTY     = 3'd4;
    localparam logic [STAT_W-1:0] ST_ZERO      = 3'd5;

    // Control sequencer states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_LAUNCH,
        S_SCAN,
        S_COMMIT
    } t_state;

    // One table slot.
    typedef struct packed {
        logic [ADDR_W-1:0] address;
        logic [SPD_W-1:0]  speed;
        logic              direction;
        logic [FUNC_W-1:0] functions;
    } t_entry;

    // Command held for the duration of one item.
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [ADDR_W-1:0] loco_address;
        logic [SPD_W-1:0]  speed_value;
        logic              direction_value;
        logic [FBIT_W-1:0] function_bit;
        logic              function_on;
    } t_cmd;

    // Search record that walks the row of cells, one cell per cycle.
    typedef struct packed {
        logic             valid;
        logic [IDX_W-1:0] idx;
        logic             hit;
        logic [IDX_W-1:0] hit_idx;
        logic             free;
        logic [IDX_W-1:0] free_idx;
        logic             a_found;
        logic [IDX_W-1:0] a_idx;
        t_entry           a_entry;
        logic             b_found;
        logic [IDX_W-1:0] b_idx;
        t_entry           b_entry;
    } t_probe;

    // Function number zero selects bit four, number n selects bit n-1.
    function automatic logic [FUNC_W-1:0] fn_func_mask(input logic [FBIT_W-1:0] fbit);
        logic [FUNC_W-1:0] mask;
        if (fbit == '0) begin
            mask = FUNC_W'(1) << 4;
        end else begin
            mask = FUNC_W'(1) << (fbit - FBIT_W'(1));
        end
        return mask;
    endfunction

endpackage

`default_nettype wire

FILE: src/lrt_cmd_if.sv
// ============================================================================
// lrt_cmd_if: command channel of the locomotive refresh table
// Valid/ready channel that carries one command item.
// ============================================================================
`default_nettype none

interface lrt_cmd_if;
    logic                       valid;
    logic                       ready;
    logic [lrt_pkg::KIND_W-1:0] kind;
    logic [lrt_pkg::ADDR_W-1:0] loco_address;
    logic [lrt_pkg::SPD_W-1:0]  speed_value;
    logic                       direction_value;
    logic [lrt_pkg::FBIT_W-1:0] function_bit;
    logic                       function_on;

    modport source (
        output valid, kind, loco_address, speed_value, direction_value,
               function_bit, function_on,
        input  ready
    );

    modport sink (
        input  valid, kind, loco_address, speed_value, direction_value,
               function_bit, function_on,
        output ready
    );
endinterface

`default_nettype wire

FILE: src/lrt_res_if.sv
// ============================================================================
// lrt_res_if: result channel of the locomotive refresh table
// Valid/ready channel that carries one status and train record item.
// ============================================================================
`default_nettype none

interface lrt_res_if;
    logic                       valid;
    logic                       ready;
    logic [lrt_pkg::STAT_W-1:0] status;
    logic [lrt_pkg::ADDR_W-1:0] train_address;
    logic [lrt_pkg::SPD_W-1:0]  train_speed;
    logic                       train_direction;
    logic [lrt_pkg::FUNC_W-1:0] train_functions;

    modport source (
        output valid, status, train_address, train_speed, train_direction,
               train_functions,
        input  ready
    );

    modport sink (
        input  valid, status, train_address, train_speed, train_direction,
               train_functions,
        output ready
    );
endinterface

`default_nettype wire

FILE: src/lrt_cell.sv
// ============================================================================
// lrt_cell: one slot of the locomotive refresh table
// Holds one entry, folds it into the search record passing by and hands the
// record to the next cell on the following cycle. Applies a committed update
// when its write enable is raised.
// ============================================================================
`default_nettype none

module lrt_cell (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic [lrt_pkg::ADDR_W-1:0]  i_rst_addr,
    input  wire lrt_pkg::t_cmd               i_cmd,
    input  wire logic [lrt_pkg::IDX_W-1:0]   i_scan,
    input  wire logic                        i_we,
    input  wire lrt_pkg::t_probe             i_probe,
    output lrt_pkg::t_probe                  o_probe
);

    lrt_pkg::t_entry r_entry;
    lrt_pkg::t_entry n_entry;
    lrt_pkg::t_probe r_probe;
    lrt_pkg::t_probe n_probe;
    logic            w_occupied;

    assign w_occupied = (r_entry.address != '0);

    // Fold this slot into the passing search record.
    always_comb begin
        n_probe     = i_probe;
        n_probe.idx = i_probe.idx + lrt_pkg::IDX_W'(1);
        if (!i_probe.hit && w_occupied && (r_entry.address == i_cmd.loco_address)) begin
            n_probe.hit     = 1'b1;
            n_probe.hit_idx = i_probe.idx;
        end
        if (!i_probe.free && !w_occupied) begin
            n_probe.free     = 1'b1;
            n_probe.free_idx = i_probe.idx;
        end
        // First occupied slot at or after the scan position.
        if (!i_probe.a_found && w_occupied && (i_probe.idx >= i_scan)) begin
            n_probe.a_found = 1'b1;
            n_probe.a_idx   = i_probe.idx;
            n_probe.a_entry = r_entry;
        end
        // First occupied slot anywhere, used when the scan wraps.
        if (!i_probe.b_found && w_occupied) begin
            n_probe.b_found = 1'b1;
            n_probe.b_idx   = i_probe.idx;
            n_probe.b_entry = r_entry;
        end
    end

    // Entry update on commit.
    always_comb begin
        n_entry = r_entry;
        if (i_we) begin
            case (i_cmd.kind)
                lrt_pkg::K_ADD:   n_entry.address   = i_cmd.loco_address;
                lrt_pkg::K_SPEED: n_entry.speed     = i_cmd.speed_value;
                lrt_pkg::K_DIR:   n_entry.direction = i_cmd.direction_value;
                lrt_pkg::K_FUNC: begin
                    if (i_cmd.function_on) begin
                        n_entry.functions = r_entry.functions
                                            | lrt_pkg::fn_func_mask(i_cmd.function_bit);
                    end else begin
                        n_entry.functions = r_entry.functions
                                            & ~lrt_pkg::fn_func_mask(i_cmd.function_bit);
                    end
                end
                default: n_entry = r_entry;
            endcase
        end
    end

    // Entry storage with its reset contents.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry.address   <= i_rst_addr;
            r_entry.speed     <= '0;
            r_entry.direction <= 1'b1;
            r_entry.functions <= lrt_pkg::FUNC_RESET;
        end else begin
            r_entry <= n_entry;
        end
    end

    // Search record stage toward the neighbor.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_probe <= '0;
        end else begin
            r_probe <= n_probe;
        end
    end

    assign o_probe = r_probe;

endmodule

`default_nettype wire

FILE: src/loco_refresh_table_core.sv
// ============================================================================
// loco_refresh_table_core: locomotive refresh table
// Table of locomotive entries kept in a row of cells. Each command sends a
// search record down the row, then commits at most one slot update and
// returns one status and train record.
// ============================================================================
//
//  Channel | Direction | Contents
//  --------+-----------+----------------------------------------------------
//  i_cmd   | in        | kind, loco_address, speed_value, direction_value,
//          |           | function_bit, function_on
//  o_res   | out       | status, train_address, train_speed,
//          |           | train_direction, train_functions
//
// An item is accepted in the idle state; in the launch state the search record
// enters the first cell, in the scan state it walks the row through the register
// of each cell and is captured as it leaves the last cell, and then the commit
// state follows. Reset loads the table contents and clears the scan position.
// A stalled result waits in the output register; the next item is accepted
// meanwhile and holds in its commit state until the output register is free.
// ============================================================================
`default_nettype none

module loco_refresh_table_core (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    lrt_cmd_if.sink    i_cmd,
    lrt_res_if.source  o_res
);

    lrt_pkg::t_state                     r_state;
    lrt_pkg::t_state                     n_state;
    lrt_pkg::t_cmd                       r_cmd;
    lrt_pkg::t_probe                     r_res;
    logic [lrt_pkg::IDX_W-1:0]           r_scan;
    logic [lrt_pkg::IDX_W-1:0]           n_scan;
    lrt_pkg::t_probe                     w_probe [lrt_pkg::TABLE_DEPTH+1];
    logic [lrt_pkg::TABLE_DEPTH-1:0]     w_we;

    logic                                w_accept;
    logic                                w_capture;
    logic                                w_commit;
    logic                                w_write;
    logic [lrt_pkg::IDX_W-1:0]           w_tgt;
    logic [lrt_pkg::STAT_W-1:0]          w_status;
    lrt_pkg::t_entry                     w_train;

    logic                                r_out_valid;
    logic [lrt_pkg::STAT_W-1:0]          r_out_status;
    lrt_pkg::t_entry                     r_out_train;

    assign w_accept  = i_cmd.valid && i_cmd.ready;
    assign w_capture = (r_state == lrt_pkg::S_SCAN) && w_probe[lrt_pkg::TABLE_DEPTH].valid;

    // Sequencer: next state and channel control.
    always_comb begin
        n_state     = r_state;
        i_cmd.ready = 1'b0;
        w_commit    = 1'b0;
        unique case (r_state)
            lrt_pkg::S_IDLE: begin
                i_cmd.ready = 1'b1;
                if (i_cmd.valid) begin
                    n_state = lrt_pkg::S_LAUNCH;
                end
            end
            lrt_pkg::S_LAUNCH: begin
                n_state = lrt_pkg::S_SCAN;
            end
            lrt_pkg::S_SCAN: begin
                if (w_probe[lrt_pkg::TABLE_DEPTH].valid) begin
                    n_state = lrt_pkg::S_COMMIT;
                end
            end
            lrt_pkg::S_COMMIT: begin
                if (!r_out_valid || o_res.ready) begin
                    w_commit = 1'b1;
                    n_state  = lrt_pkg::S_IDLE;
                end
            end
            default: n_state = lrt_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lrt_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Command capture.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd.kind            <= i_cmd.kind;
            r_cmd.loco_address    <= i_cmd.loco_address;
            r_cmd.speed_value     <= i_cmd.speed_value;
            r_cmd.direction_value <= i_cmd.direction_value;
            r_cmd.function_bit    <= i_cmd.function_bit;
            r_cmd.function_on     <= i_cmd.function_on;
        end
    end

    // Fresh search record enters the first cell in the launch cycle.
    always_comb begin
        w_probe[0]       = '0;
        w_probe[0].valid = (r_state == lrt_pkg::S_LAUNCH);
    end

    // Row of table cells.
    for (genvar gi = 0; gi < lrt_pkg::TABLE_DEPTH; gi++) begin : g_cell
        lrt_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_rst_addr ((gi == 0) ? lrt_pkg::ADDR_SLOT0_RESET : lrt_pkg::ADDR_W'(0)),
            .i_cmd      (r_cmd),
            .i_scan     (r_scan),
            .i_we       (w_we[gi]),
            .i_probe    (w_probe[gi]),
            .o_probe    (w_probe[gi+1])
        );
    end

    // Search record from the last cell.
    always_ff @(posedge i_clk) begin
        if (w_capture) begin
            r_res <= w_probe[lrt_pkg::TABLE_DEPTH];
        end
    end

    // Resolve status, update target and returned entry.
    always_comb begin
        w_status = lrt_pkg::ST_OK;
        w_write  = 1'b0;
        w_tgt    = r_res.hit_idx;
        w_train  = '0;
        n_scan   = r_scan;
        if ((r_cmd.kind <= lrt_pkg::K_FUNC) && (r_cmd.loco_address == '0)) begin
            w_status = lrt_pkg::ST_ZERO;
        end else begin
            case (r_cmd.kind)
                lrt_pkg::K_ADD: begin
                    if (r_res.hit) begin
                        w_status = lrt_pkg::ST_PRESENT;
                    end else if (!r_res.free) begin
                        w_status = lrt_pkg::ST_FULL;
                    end else begin
                        w_write = 1'b1;
                        w_tgt   = r_res.free_idx;
                    end
                end
                lrt_pkg::K_SPEED, lrt_pkg::K_DIR, lrt_pkg::K_FUNC: begin
                    if (r_res.hit) begin
                        w_write = 1'b1;
                    end else begin
                        w_status = lrt_pkg::ST_NOT_FOUND;
                    end
                end
                lrt_pkg::K_NEXT: begin
                    if (r_res.a_found) begin
                        w_train = r_res.a_entry;
                        n_scan  = (r_res.a_idx == lrt_pkg::IDX_W'(lrt_pkg::TABLE_DEPTH - 1))
                                  ? '0 : r_res.a_idx + lrt_pkg::IDX_W'(1);
                    end else if (r_res.b_found) begin
                        w_train = r_res.b_entry;
                        n_scan  = (r_res.b_idx == lrt_pkg::IDX_W'(lrt_pkg::TABLE_DEPTH - 1))
                                  ? '0 : r_res.b_idx + lrt_pkg::IDX_W'(1);
                    end else begin
                        w_status = lrt_pkg::ST_EMPTY;
                    end
                end
                default: w_status = lrt_pkg::ST_OK;
            endcase
        end
    end

    // One-hot write enables for the cells.
    always_comb begin
        for (int i = 0; i < lrt_pkg::TABLE_DEPTH; i++) begin
            w_we[i] = w_commit && w_write && (w_tgt == lrt_pkg::IDX_W'(i));
        end
    end

    // Round-robin scan position.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan <= '0;
        end else if (w_commit) begin
            r_scan <= n_scan;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_commit) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_commit) begin
            r_out_status <= w_status;
            r_out_train  <= w_train;
        end
    end

    assign o_res.valid           = r_out_valid;
    assign o_res.status          = r_out_status;
    assign o_res.train_address   = r_out_train.address;
    assign o_res.train_speed     = r_out_train.speed;
    assign o_res.train_direction = r_out_train.direction;
    assign o_res.train_functions = r_out_train.functions;

    // The search record leaves the row only while the sequencer waits for it.
    ap_probe_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_probe[lrt_pkg::TABLE_DEPTH].valid |-> (r_state == lrt_pkg::S_SCAN))
        else $error("search record left the row outside the scan state");

    // At most one cell is written per commit.
    ap_we_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_we))
        else $error("more than one cell written");

    // Cells are written only in the commit state.
    ap_we_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_we != '0) |-> (r_state == lrt_pkg::S_COMMIT))
        else $error("cell written outside the commit state");

    // The scan position stays inside the table.
    ap_scan_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_scan <= lrt_pkg::IDX_W'(lrt_pkg::TABLE_DEPTH - 1))
        else $error("scan position beyond the table");

    // A failing status never carries a train record.
    ap_fail_no_train: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && (o_res.status != lrt_pkg::ST_OK)) |-> (o_res.train_address == '0))
        else $error("train record returned with a failing status");

endmodule

`default_nettype wire
